// ----- sv/dbce_pkg.sv -----
// ----------------------------------------------------------------------------
// dbce_pkg
// Shared types and constants for the byte DMA copy engine.
// ----------------------------------------------------------------------------
package dbce_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIdxW = 3;

  // Size of the memory region starting at address zero.
  localparam logic [AddrW:0] MEMORY_BYTES = (AddrW+1)'(65536);

  localparam logic [AddrW-1:0] UART_ADDR_RST = '1;
  localparam logic [AddrW-1:0] MMIO_BASE_RST = '1;
  localparam logic [AddrW-1:0] MMIO_LAST_RST = '0;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    TGT_UART = 2'd0,
    TGT_MMIO = 2'd1,
    TGT_MEM  = 2'd2,
    TGT_BAD  = 2'd3
  } tgt_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SRC_ADDR  = 3'd0,
    REG_DST_ADDR  = 3'd1,
    REG_XFER_LEN  = 3'd2,
    REG_INC_CTRL  = 3'd3,
    REG_UART_ADDR = 3'd4,
    REG_MMIO_BASE = 3'd5,
    REG_MMIO_LAST = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0] src_addr;
    logic [AddrW-1:0] dst_addr;
    logic [AddrW-1:0] xfer_len;
    logic [2:0]       inc_ctrl;
    logic [AddrW-1:0] uart_addr;
    logic [AddrW-1:0] mmio_base;
    logic [AddrW-1:0] mmio_last;
  } cfg_t;

  // Step-bit load from an increment control write with override set.
  typedef struct packed {
    logic ld;
    logic src;
    logic dst;
  } step_ld_t;

  typedef struct packed {
    logic             busy;
    logic             completed;
    logic             error;
    logic             irq;
    logic             op_ok;
    logic             rd;
    logic [AddrW-1:0] rd_addr;
    logic             wr;
    logic [1:0]       wr_tgt;
    logic [AddrW-1:0] wr_addr;
    logic [DataW-1:0] wr_data;
    logic [AddrW-1:0] count;
  } res_t;

endpackage

// ----- sv/dbce_addr_class.sv -----
// ----------------------------------------------------------------------------
// dbce_addr_class
// Classifies a byte address as UART port, MMIO window, memory or invalid.
// ----------------------------------------------------------------------------
module dbce_addr_class #(
  parameter logic [dbce_pkg::AddrW:0] MemoryBytes = dbce_pkg::MEMORY_BYTES
) (
  input  logic [dbce_pkg::AddrW-1:0] addr_i,
  input  logic [dbce_pkg::AddrW-1:0] uart_addr_i,
  input  logic [dbce_pkg::AddrW-1:0] mmio_base_i,
  input  logic [dbce_pkg::AddrW-1:0] mmio_last_i,
  output dbce_pkg::tgt_e             tgt_o
);

  logic in_mmio;
  logic in_mem;

  assign in_mmio = (mmio_last_i >= mmio_base_i) && (addr_i >= mmio_base_i) &&
                   (addr_i <= mmio_last_i);
  assign in_mem  = {1'b0, addr_i} < MemoryBytes;

  always_comb begin
    if (addr_i == uart_addr_i) begin
      tgt_o = dbce_pkg::TGT_UART;
    end else if (in_mmio) begin
      tgt_o = dbce_pkg::TGT_MMIO;
    end else if (in_mem) begin
      tgt_o = dbce_pkg::TGT_MEM;
    end else begin
      tgt_o = dbce_pkg::TGT_BAD;
    end
  end

endmodule

// ----- sv/dbce_cfg.sv -----
// ----------------------------------------------------------------------------
// dbce_cfg
// Configuration register file. Source address, destination address and length
// writes are dropped while a transfer is running.
// ----------------------------------------------------------------------------
module dbce_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dbce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dbce_pkg::AddrW-1:0]   cfg_data_i,
  input  logic                         busy_i,
  output dbce_pkg::cfg_t               cfg_o,
  output dbce_pkg::step_ld_t           step_ld_o
);

  dbce_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d     = cfg_q;
    step_ld_o = '0;
    if (wr_en) begin
      case (cfg_index_i)
        dbce_pkg::REG_SRC_ADDR: begin
          if (!busy_i) cfg_d.src_addr = cfg_data_i;
        end
        dbce_pkg::REG_DST_ADDR: begin
          if (!busy_i) cfg_d.dst_addr = cfg_data_i;
        end
        dbce_pkg::REG_XFER_LEN: begin
          if (!busy_i) cfg_d.xfer_len = cfg_data_i;
        end
        dbce_pkg::REG_INC_CTRL: begin
          cfg_d.inc_ctrl = cfg_data_i[2:0];
          step_ld_o.ld   = cfg_data_i[0];
          step_ld_o.src  = cfg_data_i[1];
          step_ld_o.dst  = cfg_data_i[2];
        end
        dbce_pkg::REG_UART_ADDR: cfg_d.uart_addr = cfg_data_i;
        dbce_pkg::REG_MMIO_BASE: cfg_d.mmio_base = cfg_data_i;
        dbce_pkg::REG_MMIO_LAST: cfg_d.mmio_last = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dbce_pkg::cfg_t'{
        src_addr:  '0,
        dst_addr:  '0,
        xfer_len:  '0,
        inc_ctrl:  '0,
        uart_addr: dbce_pkg::UART_ADDR_RST,
        mmio_base: dbce_pkg::MMIO_BASE_RST,
        mmio_last: dbce_pkg::MMIO_LAST_RST
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/dbce_core.sv -----
// ----------------------------------------------------------------------------
// dbce_core
// Transfer state and per-beat command logic, with the result register.
// ----------------------------------------------------------------------------
module dbce_core #(
  parameter logic [dbce_pkg::AddrW:0] MemoryBytes = dbce_pkg::MEMORY_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  logic [1:0]                 cmd_op_i,
  input  logic [dbce_pkg::DataW-1:0] cmd_data_i,
  input  logic                       advance_i,
  input  dbce_pkg::cfg_t             cfg_i,
  input  dbce_pkg::step_ld_t         step_ld_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  output dbce_pkg::res_t             res_o
);

  logic [dbce_pkg::AddrW-1:0] cur_src_q, cur_src_d;
  logic [dbce_pkg::AddrW-1:0] cur_dst_q, cur_dst_d;
  logic [dbce_pkg::AddrW-1:0] moved_q, moved_d, moved_inc;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic                       err_q, err_d;
  logic                       src_step_q, src_step_d;
  logic                       dst_step_q, dst_step_d;
  logic                       res_valid_q, res_valid_d;
  dbce_pkg::res_t             res_q, res_d;
  logic                       exec;

  dbce_pkg::tgt_e cfg_src_tgt, cfg_dst_tgt, cur_src_tgt, cur_dst_tgt;

  dbce_addr_class #(.MemoryBytes(MemoryBytes)) u_cls_cfg_src (
    .addr_i(cfg_i.src_addr), .uart_addr_i(cfg_i.uart_addr),
    .mmio_base_i(cfg_i.mmio_base), .mmio_last_i(cfg_i.mmio_last),
    .tgt_o(cfg_src_tgt)
  );
  dbce_addr_class #(.MemoryBytes(MemoryBytes)) u_cls_cfg_dst (
    .addr_i(cfg_i.dst_addr), .uart_addr_i(cfg_i.uart_addr),
    .mmio_base_i(cfg_i.mmio_base), .mmio_last_i(cfg_i.mmio_last),
    .tgt_o(cfg_dst_tgt)
  );
  dbce_addr_class #(.MemoryBytes(MemoryBytes)) u_cls_cur_src (
    .addr_i(cur_src_q), .uart_addr_i(cfg_i.uart_addr),
    .mmio_base_i(cfg_i.mmio_base), .mmio_last_i(cfg_i.mmio_last),
    .tgt_o(cur_src_tgt)
  );
  dbce_addr_class #(.MemoryBytes(MemoryBytes)) u_cls_cur_dst (
    .addr_i(cur_dst_q), .uart_addr_i(cfg_i.uart_addr),
    .mmio_base_i(cfg_i.mmio_base), .mmio_last_i(cfg_i.mmio_last),
    .tgt_o(cur_dst_tgt)
  );

  assign exec      = cmd_valid_i && advance_i;
  assign moved_inc = moved_q + dbce_pkg::AddrW'(1);

  always_comb begin
    cur_src_d   = cur_src_q;
    cur_dst_d   = cur_dst_q;
    moved_d     = moved_q;
    busy_d      = busy_q;
    done_d      = done_q;
    err_d       = err_q;
    src_step_d  = src_step_q;
    dst_step_d  = dst_step_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;

    if (step_ld_i.ld) begin
      src_step_d = step_ld_i.src;
      dst_step_d = step_ld_i.dst;
    end

    if (advance_i) begin
      res_valid_d = cmd_valid_i;
    end

    if (exec) begin
      res_d       = '0;
      res_d.op_ok = 1'b1;
      case (cmd_op_i)
        dbce_pkg::OP_START: begin
          if (cfg_i.inc_ctrl[0]) begin
            src_step_d = cfg_i.inc_ctrl[1];
            dst_step_d = cfg_i.inc_ctrl[2];
          end else begin
            src_step_d = (cfg_src_tgt == dbce_pkg::TGT_MEM) ||
                         (cfg_src_tgt == dbce_pkg::TGT_BAD);
            dst_step_d = (cfg_dst_tgt == dbce_pkg::TGT_MEM) ||
                         (cfg_dst_tgt == dbce_pkg::TGT_BAD);
          end
          if (cfg_i.xfer_len == '0) begin
            cur_src_d = cfg_i.src_addr;
            cur_dst_d = cfg_i.dst_addr;
            moved_d   = '0;
            busy_d    = 1'b0;
            done_d    = 1'b1;
            err_d     = 1'b0;
            res_d.irq = 1'b1;
          end else if (cfg_src_tgt == dbce_pkg::TGT_BAD ||
                       cfg_dst_tgt == dbce_pkg::TGT_BAD) begin
            err_d       = 1'b1;
            busy_d      = 1'b0;
            done_d      = 1'b0;
            res_d.op_ok = 1'b0;
          end else begin
            cur_src_d = cfg_i.src_addr;
            cur_dst_d = cfg_i.dst_addr;
            moved_d   = '0;
            busy_d    = 1'b1;
            done_d    = 1'b0;
            err_d     = 1'b0;
          end
        end
        dbce_pkg::OP_STOP: begin
          busy_d = 1'b0;
        end
        dbce_pkg::OP_TICK: begin
          if (busy_q) begin
            if (moved_q >= cfg_i.xfer_len) begin
              busy_d = 1'b0;
              done_d = 1'b1;
            end else if (cur_src_tgt == dbce_pkg::TGT_BAD) begin
              err_d  = 1'b1;
              busy_d = 1'b0;
            end else begin
              res_d.rd      = 1'b1;
              res_d.rd_addr = cur_src_q;
              if (cur_dst_tgt == dbce_pkg::TGT_BAD) begin
                err_d  = 1'b1;
                busy_d = 1'b0;
              end else begin
                res_d.wr      = 1'b1;
                res_d.wr_tgt  = cur_dst_tgt;
                res_d.wr_addr = cur_dst_q;
                res_d.wr_data = cmd_data_i;
                moved_d       = moved_inc;
                if (src_step_q) cur_src_d = cur_src_q + dbce_pkg::AddrW'(1);
                if (dst_step_q) cur_dst_d = cur_dst_q + dbce_pkg::AddrW'(1);
                if (moved_inc >= cfg_i.xfer_len) begin
                  busy_d    = 1'b0;
                  done_d    = 1'b1;
                  res_d.irq = 1'b1;
                end
              end
            end
          end
        end
        default: begin
          res_d.op_ok = 1'b0;
        end
      endcase
      res_d.busy      = busy_d;
      res_d.completed = done_d;
      res_d.error     = err_d;
      res_d.count     = moved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_src_q   <= '0;
      cur_dst_q   <= '0;
      moved_q     <= '0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      src_step_q  <= 1'b1;
      dst_step_q  <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      cur_src_q   <= cur_src_d;
      cur_dst_q   <= cur_dst_d;
      moved_q     <= moved_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      err_q       <= err_d;
      src_step_q  <= src_step_d;
      dst_step_q  <= dst_step_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/byte_dma_copy_engine_unit.sv -----
// ----------------------------------------------------------------------------
// byte_dma_copy_engine_unit
// Single-channel byte DMA engine: start/stop/tick commands in, one status
// and bus-access beat out per command.
// ----------------------------------------------------------------------------
// Every command beat yields exactly one result beat: the command is held in the
// command register while the address check, step and count logic settle into
// the result register. A new command is taken every cycle while results drain,
// for a throughput of one beat per clock. Configuration writes are always ready
// and take effect on the next clock, except that source, destination and length
// writes are dropped while a transfer is running.
module byte_dma_copy_engine_unit #(
  parameter logic [dbce_pkg::AddrW:0] MemoryBytes = dbce_pkg::MEMORY_BYTES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dbce_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dbce_pkg::AddrW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic [dbce_pkg::DataW-1:0]   read_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         busy_res_o,
  output logic                         completed_o,
  output logic                         error_o,
  output logic                         irq_o,
  output logic                         op_ok_o,
  output logic                         read_issued_o,
  output logic [dbce_pkg::AddrW-1:0]   read_address_o,
  output logic                         write_issued_o,
  output logic [1:0]                   write_target_o,
  output logic [dbce_pkg::AddrW-1:0]   write_address_o,
  output logic [dbce_pkg::DataW-1:0]   write_data_o,
  output logic [dbce_pkg::AddrW-1:0]   transferred_count_o
);

  dbce_pkg::cfg_t     cfg;
  dbce_pkg::step_ld_t step_ld;
  dbce_pkg::res_t     res;
  logic               busy;
  logic               res_valid;
  logic               advance;

  logic                       cmd_valid_q, cmd_valid_d;
  logic [1:0]                 cmd_op_q;
  logic [dbce_pkg::DataW-1:0] cmd_data_q;

  dbce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_i      (busy),
    .cfg_o       (cfg),
    .step_ld_o   (step_ld)
  );

  // pipeline moves when the result slot is free or being drained
  assign advance    = !res_valid || out_ready_i;
  assign in_ready_o = !cmd_valid_q || advance;

  always_comb begin
    cmd_valid_d = cmd_valid_q;
    if (in_ready_o) cmd_valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= cmd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_op_q   <= op_i;
      cmd_data_q <= read_data_i;
    end
  end

  dbce_core #(.MemoryBytes(MemoryBytes)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid_q),
    .cmd_op_i    (cmd_op_q),
    .cmd_data_i  (cmd_data_q),
    .advance_i   (advance),
    .cfg_i       (cfg),
    .step_ld_i   (step_ld),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o         = res_valid;
  assign busy_res_o          = res.busy;
  assign completed_o         = res.completed;
  assign error_o             = res.error;
  assign irq_o               = res.irq;
  assign op_ok_o             = res.op_ok;
  assign read_issued_o       = res.rd;
  assign read_address_o      = res.rd_addr;
  assign write_issued_o      = res.wr;
  assign write_target_o      = res.wr_tgt;
  assign write_address_o     = res.wr_addr;
  assign write_data_o        = res.wr_data;
  assign transferred_count_o = res.count;

endmodule
